/* sv/cmnt_pkg.sv */
// Shared types, codes and arithmetic helpers for the Cholesky normal transform.
package cmnt_pkg;

    localparam logic [1:0] REQ_COV  = 2'd0;
    localparam logic [1:0] REQ_MEAN = 2'd1;
    localparam logic [1:0] REQ_VAR  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NPD   = 2'd1;
    localparam logic [1:0] ST_SING  = 2'd2;
    localparam logic [1:0] ST_NOFAC = 2'd3;

    localparam int         PADDR_W     = 3;
    localparam logic       REG_DIM     = 1'b0;
    localparam logic [3:0] DIM_RESET   = 4'd8;

    localparam int         UNIT_CNT_W  = 6;
    localparam logic [5:0] SQRT_LAST   = 6'd31;
    localparam logic [5:0] DIV_LAST    = 6'd63;

    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_LOAD_COV,
        ACC_LOAD_MEAN,
        ACC_SUB,
        ACC_ADD
    } t_acc_op;

    typedef enum logic {
        UM_SQRT,
        UM_DIV
    } t_unit_mode;

    typedef struct packed {
        t_acc_op    op;
        logic       cov_wr;
        logic       mean_wr;
        logic       var_wr;
        logic       fac_wr;
        logic       piv_load;
        logic       unit_start;
        t_unit_mode unit_mode;
        logic       vec_start;
        logic       emit;
        logic       emit_vec;
        logic [1:0] status;
        logic [2:0] out_index;
        logic       last;
    } t_dp_cmd;

    typedef struct packed {
        logic pipe_empty;
        logic acc_neg;
        logic acc_zero;
        logic unit_busy;
        logic unit_done;
        logic out_free;
    } t_dp_stat;

    function automatic logic signed [63:0] f_sat_add(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return s[63:0];
    endfunction

    function automatic logic signed [31:0] f_sat32(input logic signed [63:0] v);
        if (v[63:31] == '0 || v[63:31] == '1) begin
            return v[31:0];
        end
        return v[63] ? 32'h8000_0000 : 32'h7fff_ffff;
    endfunction

endpackage

/* sv/cmnt_itu.sv */
// Iterative unit: bitwise integer square root and restoring signed division.
module cmnt_itu (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  cmnt_pkg::t_unit_mode    i_mode,
    input  logic signed [63:0]      i_x,
    input  logic [31:0]             i_div,
    output logic                    o_busy,
    output logic                    o_done,
    output logic [31:0]             o_res
);
    import cmnt_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    t_unit_mode            r_mode;
    logic [UNIT_CNT_W-1:0] r_cnt;
    logic [63:0]           r_sh;
    logic [35:0]           r_rem;
    logic [31:0]           r_root;
    logic [31:0]           r_div;
    logic                  r_neg;

    logic [35:0] w_rem_s;
    logic [35:0] w_trial;
    logic [32:0] w_rem_d;
    logic        w_qbit;

    assign w_rem_s = {r_rem[33:0], r_sh[63:62]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_rem_d = {r_rem[31:0], r_sh[63]};
    assign w_qbit  = (w_rem_d >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_start) begin
            r_mode <= i_mode;
            r_rem  <= '0;
            r_root <= '0;
            r_div  <= i_div;
            r_neg  <= i_x[63];
            if (i_mode == UM_SQRT) begin
                r_sh  <= i_x;
                r_cnt <= SQRT_LAST;
            end else begin
                r_sh  <= i_x[63] ? -i_x : i_x;
                r_cnt <= DIV_LAST;
            end
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_mode == UM_SQRT) begin
                r_sh <= {r_sh[61:0], 2'b00};
                if (w_rem_s >= w_trial) begin
                    r_rem  <= w_rem_s - w_trial;
                    r_root <= {r_root[30:0], 1'b1};
                end else begin
                    r_rem  <= w_rem_s;
                    r_root <= {r_root[30:0], 1'b0};
                end
            end else begin
                r_sh  <= {r_sh[62:0], w_qbit};
                r_rem <= w_qbit ? 36'(w_rem_d - {1'b0, r_div}) : 36'(w_rem_d);
            end
        end
    end

    always_comb begin
        if (r_mode == UM_SQRT) begin
            o_res = r_root[31] ? 32'h7fff_ffff : r_root;
        end else if (r_sh[63:31] != '0) begin
            o_res = r_neg ? 32'h8000_0000 : 32'h7fff_ffff;
        end else begin
            o_res = r_neg ? -r_sh[31:0] : r_sh[31:0];
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;

endmodule

/* sv/cmnt_dp.sv */
// Datapath: stores, MAC pipeline, iterative unit and output register.
module cmnt_dp #(
    parameter int MAX_DIM   = 8,
    parameter int FRAC_BITS = 16,
    parameter int IW        = 3,
    parameter int AW        = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cmnt_pkg::t_dp_cmd    i_cmd,
    input  logic [AW-1:0]        i_cov_addr,
    input  logic [AW-1:0]        i_fa_addr,
    input  logic [AW-1:0]        i_fb_addr,
    input  logic [IW-1:0]        i_vidx,
    input  logic                 i_in_accept,
    input  logic signed [31:0]   i_value,
    input  logic                 i_out_ready,
    output cmnt_pkg::t_dp_stat   o_stat,
    output logic                 o_out_valid,
    output logic [1:0]           o_status,
    output logic [2:0]           o_out_index,
    output logic signed [31:0]   o_out_value,
    output logic                 o_all_nonnegative,
    output logic                 o_last
);
    import cmnt_pkg::*;

    logic [31:0] r_cov_mem [MAX_DIM*MAX_DIM];
    logic [31:0] r_fac_mem [MAX_DIM*MAX_DIM];
    logic [31:0] r_mean    [MAX_DIM];
    logic [31:0] r_var     [MAX_DIM];

    logic [31:0]        r_value;
    logic [31:0]        r_cov_q;
    logic [31:0]        r_fa_q;
    logic [31:0]        r_fb_q;
    logic [31:0]        r_mean_q;
    logic [31:0]        r_var_q;
    t_acc_op            r_op1;
    t_acc_op            r_op2;
    logic signed [63:0] r_prod;
    logic signed [63:0] r_acc;
    logic [31:0]        r_piv;
    logic               r_nonneg;
    logic               r_out_valid;

    logic [31:0]        w_mul_b;
    logic signed [63:0] w_prod;
    logic signed [63:0] w_cov_ext;
    logic signed [63:0] w_mean_ext;
    logic signed [31:0] w_x;
    logic               w_nn;
    logic               w_unit_busy;
    logic               w_unit_done;
    logic [31:0]        w_unit_res;

    cmnt_itu u_itu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.unit_start),
        .i_mode  (i_cmd.unit_mode),
        .i_x     (r_acc),
        .i_div   (r_piv),
        .o_busy  (w_unit_busy),
        .o_done  (w_unit_done),
        .o_res   (w_unit_res)
    );

    assign w_mul_b    = (r_op1 == ACC_ADD) ? r_var_q : r_fb_q;
    assign w_prod     = $signed(r_fa_q) * $signed(w_mul_b);
    assign w_cov_ext  = {{32{r_cov_q[31]}}, r_cov_q} <<< FRAC_BITS;
    assign w_mean_ext = {{32{r_mean_q[31]}}, r_mean_q} <<< FRAC_BITS;
    assign w_x        = f_sat32(r_acc >>> FRAC_BITS);
    assign w_nn       = r_nonneg & ~w_x[31];

    always_ff @(posedge i_clk) begin
        if (i_in_accept) begin
            r_value <= i_value;
        end
        if (i_cmd.cov_wr) begin
            r_cov_mem[i_cov_addr] <= r_value;
        end
        if (i_cmd.fac_wr) begin
            r_fac_mem[i_fa_addr] <= w_unit_res;
        end
        if (i_cmd.mean_wr) begin
            r_mean[i_vidx] <= r_value;
        end
        if (i_cmd.var_wr) begin
            r_var[i_vidx] <= r_value;
        end
        r_cov_q  <= r_cov_mem[i_cov_addr];
        r_fa_q   <= r_fac_mem[i_fa_addr];
        r_fb_q   <= r_fac_mem[i_fb_addr];
        r_mean_q <= r_mean[i_vidx];
        r_var_q  <= r_var[i_vidx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op1       <= ACC_NONE;
            r_op2       <= ACC_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_op1 <= i_cmd.op;
            r_op2 <= r_op1;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        case (r_op1)
            ACC_LOAD_COV:  r_prod <= w_cov_ext;
            ACC_LOAD_MEAN: r_prod <= w_mean_ext;
            default:       r_prod <= w_prod;
        endcase
        case (r_op2)
            ACC_LOAD_COV,
            ACC_LOAD_MEAN: r_acc <= r_prod;
            ACC_SUB:       r_acc <= f_sat_add(r_acc, -r_prod);
            ACC_ADD:       r_acc <= f_sat_add(r_acc, r_prod);
            default:       r_acc <= r_acc;
        endcase
        if (i_cmd.piv_load) begin
            r_piv <= w_unit_res;
        end
        if (i_cmd.vec_start) begin
            r_nonneg <= 1'b1;
        end else if (i_cmd.emit && i_cmd.emit_vec) begin
            r_nonneg <= w_nn;
        end
        if (i_cmd.emit) begin
            o_status          <= i_cmd.status;
            o_out_index       <= i_cmd.out_index;
            o_last            <= i_cmd.last;
            o_out_value       <= i_cmd.emit_vec ? w_x : '0;
            o_all_nonnegative <= i_cmd.emit_vec ? w_nn : 1'b0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_stat.pipe_empty = (r_op1 == ACC_NONE) && (r_op2 == ACC_NONE);
    assign o_stat.acc_neg    = r_acc[63];
    assign o_stat.acc_zero   = (r_acc == '0);
    assign o_stat.unit_busy  = w_unit_busy;
    assign o_stat.unit_done  = w_unit_done;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

endmodule

/* sv/cmnt_ctrl.sv */
// Controller: request decode, factorization and transform sequencing.
module cmnt_ctrl #(
    parameter int MAX_DIM = 8,
    parameter int IW      = 3,
    parameter int AW      = 6,
    parameter int NW      = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [3:0]           i_dim,
    input  logic                 i_cfg_wr,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_req_type,
    input  logic [2:0]           i_row_index,
    input  logic [2:0]           i_col_index,
    input  cmnt_pkg::t_dp_stat   i_stat,
    output cmnt_pkg::t_dp_cmd    o_cmd,
    output logic [AW-1:0]        o_cov_addr,
    output logic [AW-1:0]        o_fa_addr,
    output logic [AW-1:0]        o_fb_addr,
    output logic [IW-1:0]        o_vidx
);
    import cmnt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE,
        S_PIV_LOAD, S_PIV_MAC, S_PIV_WAIT, S_SQRT,
        S_COL_LOAD, S_COL_MAC, S_COL_WAIT, S_DIV,
        S_OUT_LOAD, S_OUT_MAC, S_OUT_WAIT, S_ACK
    } t_state;

    t_state          r_state, n_state;
    logic [1:0]      r_type, n_type;
    logic [2:0]      r_row, n_row;
    logic [2:0]      r_col, n_col;
    logic [NW-1:0]   r_i, n_i;
    logic [NW-1:0]   r_j, n_j;
    logic [NW-1:0]   r_k, n_k;
    logic            r_factored, n_factored;
    logic [1:0]      r_err, n_err;
    logic [NW-1:0]   w_n;
    logic            w_row_ok;
    logic            w_col_ok;
    logic            w_row_last;

    function automatic logic [AW-1:0] f_addr(input int r, input int c);
        return AW'(r * MAX_DIM + c);
    endfunction

    always_comb begin
        if (i_dim == '0) begin
            w_n = NW'(1);
        end else if (int'(i_dim) > MAX_DIM) begin
            w_n = NW'(MAX_DIM);
        end else begin
            w_n = NW'(i_dim);
        end
    end

    assign w_row_ok   = int'(r_row) < int'(w_n);
    assign w_col_ok   = int'(r_col) < int'(w_n);
    assign w_row_last = int'(r_row) == int'(w_n) - 1;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd      = '0;
        o_cov_addr = '0;
        o_fa_addr  = '0;
        o_fb_addr  = '0;
        o_vidx     = '0;
        n_state    = r_state;
        n_type     = r_type;
        n_row      = r_row;
        n_col      = r_col;
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        n_factored = r_factored;
        n_err      = r_err;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_type  = i_req_type;
                    n_row   = i_row_index;
                    n_col   = i_col_index;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_ACK;
                o_vidx  = IW'(r_row);
                if (r_type == REQ_COV && w_row_ok && w_col_ok) begin
                    o_cmd.cov_wr = 1'b1;
                    o_cov_addr   = f_addr(int'(r_row), int'(r_col));
                    if (w_row_last && int'(r_col) == int'(w_n) - 1) begin
                        n_factored = 1'b0;
                        n_err      = ST_OK;
                        n_j        = '0;
                        n_state    = S_PIV_LOAD;
                    end
                end else if (r_type == REQ_MEAN && w_row_ok) begin
                    o_cmd.mean_wr = 1'b1;
                end else if (r_type == REQ_VAR && w_row_ok) begin
                    o_cmd.var_wr = 1'b1;
                    if (w_row_last && r_factored) begin
                        o_cmd.vec_start = 1'b1;
                        n_i             = '0;
                        n_state         = S_OUT_LOAD;
                    end
                end
            end
            S_PIV_LOAD: begin
                o_cmd.op   = ACC_LOAD_COV;
                o_cov_addr = f_addr(int'(r_j), int'(r_j));
                n_k        = '0;
                n_state    = S_PIV_MAC;
            end
            S_PIV_MAC: begin
                if (r_k < r_j) begin
                    o_cmd.op  = ACC_SUB;
                    o_fa_addr = f_addr(int'(r_j), int'(r_k));
                    o_fb_addr = f_addr(int'(r_j), int'(r_k));
                    n_k       = r_k + 1'b1;
                end else begin
                    n_state = S_PIV_WAIT;
                end
            end
            S_PIV_WAIT: begin
                if (i_stat.pipe_empty) begin
                    if (i_stat.acc_neg) begin
                        n_err   = ST_NPD;
                        n_state = S_ACK;
                    end else if (i_stat.acc_zero) begin
                        n_err   = ST_SING;
                        n_state = S_ACK;
                    end else begin
                        o_cmd.unit_start = 1'b1;
                        o_cmd.unit_mode  = UM_SQRT;
                        n_state          = S_SQRT;
                    end
                end
            end
            S_SQRT: begin
                if (i_stat.unit_done) begin
                    o_cmd.fac_wr   = 1'b1;
                    o_cmd.piv_load = 1'b1;
                    o_fa_addr      = f_addr(int'(r_j), int'(r_j));
                    n_i            = r_j + 1'b1;
                    n_state        = S_COL_LOAD;
                end
            end
            S_COL_LOAD: begin
                if (r_i < w_n) begin
                    o_cmd.op   = ACC_LOAD_COV;
                    o_cov_addr = f_addr(int'(r_i), int'(r_j));
                    n_k        = '0;
                    n_state    = S_COL_MAC;
                end else if (int'(r_j) + 1 < int'(w_n)) begin
                    n_j     = r_j + 1'b1;
                    n_state = S_PIV_LOAD;
                end else begin
                    n_factored = 1'b1;
                    n_state    = S_ACK;
                end
            end
            S_COL_MAC: begin
                if (r_k < r_j) begin
                    o_cmd.op  = ACC_SUB;
                    o_fa_addr = f_addr(int'(r_i), int'(r_k));
                    o_fb_addr = f_addr(int'(r_j), int'(r_k));
                    n_k       = r_k + 1'b1;
                end else begin
                    n_state = S_COL_WAIT;
                end
            end
            S_COL_WAIT: begin
                if (i_stat.pipe_empty) begin
                    o_cmd.unit_start = 1'b1;
                    o_cmd.unit_mode  = UM_DIV;
                    n_state          = S_DIV;
                end
            end
            S_DIV: begin
                if (i_stat.unit_done) begin
                    o_cmd.fac_wr = 1'b1;
                    o_fa_addr    = f_addr(int'(r_i), int'(r_j));
                    n_i          = r_i + 1'b1;
                    n_state      = S_COL_LOAD;
                end
            end
            S_OUT_LOAD: begin
                o_cmd.op = ACC_LOAD_MEAN;
                o_vidx   = r_i[IW-1:0];
                n_k      = '0;
                n_state  = S_OUT_MAC;
            end
            S_OUT_MAC: begin
                if (r_k <= r_i) begin
                    o_cmd.op  = ACC_ADD;
                    o_fa_addr = f_addr(int'(r_i), int'(r_k));
                    o_vidx    = r_k[IW-1:0];
                    n_k       = r_k + 1'b1;
                end else begin
                    n_state = S_OUT_WAIT;
                end
            end
            S_OUT_WAIT: begin
                if (i_stat.pipe_empty && i_stat.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_vec  = 1'b1;
                    o_cmd.status    = ST_OK;
                    o_cmd.out_index = 3'(r_i);
                    o_cmd.last      = (int'(r_i) == int'(w_n) - 1);
                    if (int'(r_i) == int'(w_n) - 1) begin
                        n_state = S_IDLE;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = S_OUT_LOAD;
                    end
                end
            end
            S_ACK: begin
                if (i_stat.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.out_index = r_row;
                    o_cmd.last      = 1'b1;
                    if (r_factored) begin
                        o_cmd.status = ST_OK;
                    end else if (r_err != ST_OK) begin
                        o_cmd.status = r_err;
                    end else begin
                        o_cmd.status = ST_NOFAC;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (i_cfg_wr) begin
            n_factored = 1'b0;
            n_err      = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_type     <= '0;
            r_row      <= '0;
            r_col      <= '0;
            r_i        <= '0;
            r_j        <= '0;
            r_k        <= '0;
            r_factored <= 1'b0;
            r_err      <= ST_OK;
        end else begin
            r_state    <= n_state;
            r_type     <= n_type;
            r_row      <= n_row;
            r_col      <= n_col;
            r_i        <= n_i;
            r_j        <= n_j;
            r_k        <= n_k;
            r_factored <= n_factored;
            r_err      <= n_err;
        end
    end

`ifndef SYNTHESIS
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_stat.out_free)
        else $error("result written into occupied output register");
    a_unit_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.unit_start |-> (!i_stat.unit_busy && i_stat.pipe_empty))
        else $error("unit started with busy unit or pending accumulation");
    a_unit_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.unit_start |=> i_stat.unit_busy)
        else $error("unit did not start");
    a_fac_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fac_wr |-> i_stat.unit_done)
        else $error("factor written without unit result");
`endif

endmodule

/* sv/cholesky_multivariate_normal_transform.sv */
// Top level: Cholesky factorization and multivariate normal transform.
//
//  channel   direction  handshake                  payload
//  in        input      i_in_valid / o_in_ready    i_req_type i_row_index i_col_index i_value
//  out       output     o_out_valid / i_out_ready  o_status o_out_index o_out_value
//                                                  o_all_nonnegative o_last
//  cfg       APB        psel penable pwrite pready paddr pwdata prdata
//
// Mean, variate and load requests are decoded and acknowledged via the output register.
// The trigger element factors the matrix: per column j, a load and j MAC terms plus
// a 32-step square root, then per row below it a load and j MAC terms plus a 64-step division.
// The final variate produces n results, element i from its mean plus i+1 MAC terms.
// Reset is synchronous; the factor store needs no clearing pass.
// A stalled output holds its result; one further request is taken meanwhile.
module cholesky_multivariate_normal_transform #(
    parameter int MAX_DIM   = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_req_type,
    input  logic [2:0]                      i_row_index,
    input  logic [2:0]                      i_col_index,
    input  logic signed [31:0]              i_value,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [1:0]                      o_status,
    output logic [2:0]                      o_out_index,
    output logic signed [31:0]              o_out_value,
    output logic                            o_all_nonnegative,
    output logic                            o_last,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cmnt_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import cmnt_pkg::*;

    localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
    localparam int NW = $clog2(MAX_DIM + 1);

    logic [3:0]    r_dim;
    logic          w_cfg_wr;
    logic          w_in_accept;
    t_dp_cmd       w_cmd;
    t_dp_stat      w_stat;
    logic [AW-1:0] w_cov_addr;
    logic [AW-1:0] w_fa_addr;
    logic [AW-1:0] w_fb_addr;
    logic [IW-1:0] w_vidx;

    assign pready      = 1'b1;
    assign w_cfg_wr    = psel && penable && pwrite && (paddr[2] == REG_DIM);
    assign prdata      = (paddr[2] == REG_DIM) ? {28'd0, r_dim} : 32'd0;
    assign w_in_accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim <= DIM_RESET;
        end else if (w_cfg_wr) begin
            r_dim <= pwdata[3:0];
        end
    end

    cmnt_ctrl #(
        .MAX_DIM (MAX_DIM),
        .IW      (IW),
        .AW      (AW),
        .NW      (NW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dim       (r_dim),
        .i_cfg_wr    (w_cfg_wr),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .i_row_index (i_row_index),
        .i_col_index (i_col_index),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_cov_addr  (w_cov_addr),
        .o_fa_addr   (w_fa_addr),
        .o_fb_addr   (w_fb_addr),
        .o_vidx      (w_vidx)
    );

    cmnt_dp #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS),
        .IW        (IW),
        .AW        (AW)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_cov_addr        (w_cov_addr),
        .i_fa_addr         (w_fa_addr),
        .i_fb_addr         (w_fb_addr),
        .i_vidx            (w_vidx),
        .i_in_accept       (w_in_accept),
        .i_value           (i_value),
        .i_out_ready       (i_out_ready),
        .o_stat            (w_stat),
        .o_out_valid       (o_out_valid),
        .o_status          (o_status),
        .o_out_index       (o_out_index),
        .o_out_value       (o_out_value),
        .o_all_nonnegative (o_all_nonnegative),
        .o_last            (o_last)
    );

endmodule
